FILE: rtl/mtdm_pkg.sv
// Shared types and constants for the multitap delay mixer.
// Register map, command word between controller and datapath, arithmetic widths.
`timescale 1ns / 1ps
`default_nettype none

package mtdm_pkg;

  localparam int REG_W      = 3;
  localparam int DATA_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int DELAY_W    = 12;
  localparam int COUNT_W    = 2;
  localparam int CFG_TAPS   = 3;
  localparam int TAP_IDX_W  = 2;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int ACC_W      = PROD_W + 2;
  localparam int LO_W       = 18;
  localparam int HI_W       = ACC_W - LO_W;
  localparam int LO_PROD_W  = LO_W + GAIN_W;
  localparam int HI_PROD_W  = HI_W + GAIN_W + 1;
  localparam int TOT_W      = HI_PROD_W + LO_W;
  localparam int FRAC_SHIFT = 24;
  localparam int Y_W        = TOT_W - FRAC_SHIFT;

  typedef enum logic [REG_W-1:0] {
    REG_ACTIVE_TAPS = 3'd0,
    REG_OUT_GAIN    = 3'd1,
    REG_TAP0_DELAY  = 3'd2,
    REG_TAP1_DELAY  = 3'd3,
    REG_TAP2_DELAY  = 3'd4,
    REG_TAP0_GAIN   = 3'd5,
    REG_TAP1_GAIN   = 3'd6,
    REG_TAP2_GAIN   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic                 wr;
    logic                 rd;
    logic [TAP_IDX_W-1:0] rd_tap;
    logic                 mac;
    logic                 mul_lo;
    logic                 mul_hi;
    logic                 load;
  } mtdm_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/mtdm_cfg.sv
// Configuration registers of the multitap delay mixer.
// Clamps tap count and tap delays to the built size; depends on mtdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtdm_cfg import mtdm_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int TAPS  = 3
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [REG_W-1:0]                      cfg_idx_i,
  input  wire logic [DATA_W-1:0]                     cfg_data_i,
  output logic      [COUNT_W-1:0]                    n_taps_o,
  output logic      [GAIN_W-1:0]                     out_gain_o,
  output logic      [CFG_TAPS-1:0][$clog2(DEPTH)-1:0] tap_delay_o,
  output logic      [CFG_TAPS-1:0][GAIN_W-1:0]       tap_gain_o
);

  localparam int AW   = $clog2(DEPTH);
  localparam int NTAP = (TAPS < CFG_TAPS) ? TAPS : CFG_TAPS;

  logic [COUNT_W-1:0]                active_q;
  logic [GAIN_W-1:0]                 master_q;
  logic [CFG_TAPS-1:0][DELAY_W-1:0]  delay_q;
  logic [CFG_TAPS-1:0][GAIN_W-1:0]   gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= COUNT_W'(1);
      master_q <= '0;
      delay_q  <= '0;
      gain_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ACTIVE_TAPS: active_q <= cfg_data_i[COUNT_W-1:0];
        REG_OUT_GAIN:    master_q <= cfg_data_i[GAIN_W-1:0];
        default: begin
          for (int t = 0; t < NTAP; t++) begin
            if (cfg_idx_i == REG_W'(int'(REG_TAP0_DELAY) + t)) begin
              delay_q[t] <= cfg_data_i[DELAY_W-1:0];
            end
            if (cfg_idx_i == REG_W'(int'(REG_TAP0_GAIN) + t)) begin
              gain_q[t] <= cfg_data_i[GAIN_W-1:0];
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    if (active_q == '0) begin
      n_taps_o = COUNT_W'(1);
    end else if (int'(active_q) > NTAP) begin
      n_taps_o = COUNT_W'(NTAP);
    end else begin
      n_taps_o = active_q;
    end
    for (int t = 0; t < CFG_TAPS; t++) begin
      if (int'(delay_q[t]) > DEPTH - 1) begin
        tap_delay_o[t] = AW'(DEPTH - 1);
      end else begin
        tap_delay_o[t] = AW'(delay_q[t]);
      end
    end
  end

  assign out_gain_o = master_q;
  assign tap_gain_o = gain_q;

endmodule

`default_nettype wire

FILE: rtl/mtdm_ctrl.sv
// Sequencing controller of the multitap delay mixer.
// Steps write, tap reads, multiply-accumulates, scaling and output load; uses mtdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtdm_ctrl import mtdm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  input  wire logic [COUNT_W-1:0] n_taps_i,
  output mtdm_cmd_t               cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAP,
    S_MUL_LO,
    S_MUL_HI,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [COUNT_W-1:0] cnt_q;
  logic               out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.wr     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.rd     = (state_q == S_TAP) && (cnt_q < n_taps_i);
    cmd_o.rd_tap = cnt_q;
    cmd_o.mac    = (state_q == S_TAP) && (cnt_q != '0);
    cmd_o.mul_lo = (state_q == S_MUL_LO);
    cmd_o.mul_hi = (state_q == S_MUL_HI);
    cmd_o.load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (in_valid_i) begin
            state_q <= S_TAP;
          end
        end
        S_TAP: begin
          cnt_q <= cnt_q + COUNT_W'(1);
          if (cnt_q == n_taps_i) begin
            state_q <= S_MUL_LO;
          end
        end
        S_MUL_LO: state_q <= S_MUL_HI;
        S_MUL_HI: state_q <= S_DONE;
        S_DONE: begin
          if (cmd_o.load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/mtdm_dp.sv
// Datapath of the multitap delay mixer: delay memory, tap MAC, master scaling.
// Driven by the mtdm_ctrl command word; uses mtdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtdm_dp import mtdm_pkg::*; #(
  parameter int DEPTH = 4096
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire mtdm_cmd_t                              cmd_i,
  input  wire logic signed [SAMPLE_W-1:0]             sample_in_i,
  input  wire logic [GAIN_W-1:0]                      out_gain_i,
  input  wire logic [CFG_TAPS-1:0][$clog2(DEPTH)-1:0] tap_delay_i,
  input  wire logic [CFG_TAPS-1:0][GAIN_W-1:0]        tap_gain_i,
  output logic signed [SAMPLE_W-1:0]                  sample_out_o
);

  localparam int AW = $clog2(DEPTH);

  logic [SAMPLE_W-1:0]        mem [DEPTH];
  logic [SAMPLE_W-1:0]        rdata_q;
  logic                       rd_ok_q;
  logic [TAP_IDX_W-1:0]       rd_tap_q;
  logic [AW-1:0]              wp_q;
  logic                       wrapped_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic [LO_PROD_W-1:0]       prod_lo_q;
  logic signed [TOT_W-1:0]    total_q;
  logic signed [SAMPLE_W-1:0] out_q;

  logic [AW-1:0]              rd_delay;
  logic [AW:0]                pos_wide;
  logic [AW-1:0]              rd_pos;
  logic                       rd_ok;
  logic signed [SAMPLE_W-1:0] tap_smp;
  logic signed [GAIN_W:0]     tap_gain;
  logic signed [PROD_W-1:0]   tap_prod;
  logic [LO_W-1:0]            acc_lo;
  logic signed [HI_W-1:0]     acc_hi;
  logic signed [GAIN_W:0]     mg_s;
  logic signed [HI_PROD_W-1:0] hi_prod;
  logic signed [TOT_W-1:0]    rnd;
  logic signed [Y_W-1:0]      y;
  logic signed [SAMPLE_W-1:0] y_sat;

  always_comb begin
    rd_delay = tap_delay_i[cmd_i.rd_tap];
    if (wp_q >= rd_delay) begin
      pos_wide = (AW + 1)'(wp_q) - (AW + 1)'(rd_delay);
    end else begin
      pos_wide = (AW + 1)'(wp_q) + (AW + 1)'(DEPTH) - (AW + 1)'(rd_delay);
    end
    rd_pos   = pos_wide[AW-1:0];
    rd_ok    = wrapped_q || (rd_pos <= wp_q);
    tap_smp  = rd_ok_q ? $signed(rdata_q) : '0;
    tap_gain = $signed({1'b0, tap_gain_i[rd_tap_q]});
    tap_prod = tap_smp * tap_gain;
    acc_lo   = acc_q[LO_W-1:0];
    acc_hi   = acc_q[ACC_W-1:LO_W];
    mg_s     = $signed({1'b0, out_gain_i});
    hi_prod  = acc_hi * mg_s;
    rnd      = total_q + TOT_W'(1 << (FRAC_SHIFT - 1));
    y        = rnd[TOT_W-1:FRAC_SHIFT];
    if (y > Y_W'(signed'(32767))) begin
      y_sat = 16'sh7fff;
    end else if (y < -Y_W'(signed'(32768))) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = y[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[wp_q] <= sample_in_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[rd_pos];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
    end else if (cmd_i.load) begin
      if (wp_q == AW'(DEPTH - 1)) begin
        wp_q      <= '0;
        wrapped_q <= 1'b1;
      end else begin
        wp_q <= wp_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_ok_q  <= rd_ok;
      rd_tap_q <= cmd_i.rd_tap;
    end
    if (cmd_i.wr) begin
      acc_q <= '0;
    end else if (cmd_i.mac) begin
      acc_q <= acc_q + ACC_W'(tap_prod);
    end
    if (cmd_i.mul_lo) begin
      prod_lo_q <= LO_PROD_W'(acc_lo) * LO_PROD_W'(out_gain_i);
    end
    if (cmd_i.mul_hi) begin
      total_q <= (TOT_W'(hi_prod) <<< LO_W) + $signed(TOT_W'(prod_lo_q));
    end
    if (cmd_i.load) begin
      out_q <= y_sat;
    end
  end

  assign sample_out_o = out_q;

endmodule

`default_nettype wire

FILE: rtl/multitap_delay_mixer.sv
// Channel    | signals                        | payload
// input      | in_valid_i, in_stall_o         | sample_in_i, one word per sample
// output     | out_valid_o, out_stall_i       | sample_out_o, one word per sample
// config     | cfg_we_i, cfg_idx_i            | cfg_data_i, write only
//
// One word steps from accept through the write, the tap reads, the scaling multiplies
// and the output load; the tap loop runs one delay-memory read port, one read per cycle,
// overlapped with the MAC.
// The output register holds a finished word while the next input word is processed.
// Reset is asynchronous, active low; unwritten memory entries read as zero via a wrap flag.
// A stalled output holds the last word; the finishing step waits for the register to free.
// Top level; instantiates mtdm_cfg, mtdm_ctrl and mtdm_dp, uses mtdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module multitap_delay_mixer import mtdm_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int TAPS  = 3
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0]      sample_out_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [REG_W-1:0]           cfg_idx_i,
  input  wire logic [DATA_W-1:0]          cfg_data_i
);

  localparam int AW = $clog2(DEPTH);

  logic [COUNT_W-1:0]                n_taps;
  logic [GAIN_W-1:0]                 out_gain;
  logic [CFG_TAPS-1:0][AW-1:0]       tap_delay;
  logic [CFG_TAPS-1:0][GAIN_W-1:0]   tap_gain;
  mtdm_cmd_t                         cmd;

  mtdm_cfg #(
    .DEPTH(DEPTH),
    .TAPS (TAPS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .n_taps_o   (n_taps),
    .out_gain_o (out_gain),
    .tap_delay_o(tap_delay),
    .tap_gain_o (tap_gain)
  );

  mtdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .n_taps_i   (n_taps),
    .cmd_o      (cmd)
  );

  mtdm_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sample_in_i (sample_in_i),
    .out_gain_i  (out_gain),
    .tap_delay_i (tap_delay),
    .tap_gain_i  (tap_gain),
    .sample_out_o(sample_out_o)
  );

endmodule

`default_nettype wire

FILE: rtl/mtdm_chk.sv
// Port-level checker for the multitap delay mixer, bound to the top level.
// Sees only top-level ports; uses mtdm_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module mtdm_chk import mtdm_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [SAMPLE_W-1:0] sample_out_o
);

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o ##1 in_stall_o ##1 in_stall_o ##1 in_stall_o)
    else $error("input taken again too soon after a word was accepted");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result appeared the cycle after an accept");

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while no word was in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o))
    else $error("stalled output word changed");

endmodule

bind multitap_delay_mixer mtdm_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .sample_out_o(sample_out_o)
);

`default_nettype wire
